@@ rtl/core/pit_pkg.sv @@
// Shared constants, types and helper functions for the four-channel interval timer.
package pit_pkg;

   localparam int NUM_CHANNELS       = 4;
   localparam int TIMERS_PER_CHANNEL = 4;
   localparam int NUM_TIMERS         = NUM_CHANNELS * TIMERS_PER_CHANNEL;
   localparam int CH_W               = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [31:0] ID_VALUE    = 32'h0303_1000;
   localparam logic [7:0]  ADDR_ID     = 8'h00;
   localparam logic [7:0]  ADDR_CFG    = 8'h10;
   localparam logic [7:0]  ADDR_IRQ_EN = 8'h14;
   localparam logic [7:0]  ADDR_IRQ_ST = 8'h18;
   localparam logic [7:0]  ADDR_TMR_EN = 8'h1C;
   localparam logic [7:0]  ADDR_CH_BASE = 8'h20;
   localparam logic [8:0]  ADDR_CH_END = 9'(32'h20 + 16 * NUM_CHANNELS);

   localparam logic [3:0] OFF_CTRL   = 4'h0;
   localparam logic [3:0] OFF_RELOAD = 4'h4;
   localparam logic [3:0] OFF_COUNT  = 4'h8;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } pit_op_type;

   typedef enum logic [2:0] {
      MODE_T32       = 3'd1,
      MODE_T16X2     = 3'd2,
      MODE_T8X4      = 3'd3,
      MODE_PWM16     = 3'd4,
      MODE_T16_PWM8  = 3'd6,
      MODE_T8X2_PWM8 = 3'd7
   } pit_mode_type;

   typedef struct packed {
      pit_op_type  op;
      logic [7:0]  address;
      logic [31:0] write_data;
      logic        pclk_tick;
      logic        ext_tick;
   } pit_item_type;

   typedef struct packed {
      logic        stop;
      logic        start;
      logic [31:0] limit;
   } pit_cmd_type;

   typedef pit_cmd_type [TIMERS_PER_CHANNEL-1:0] pit_chan_cmd_type;
   typedef logic [TIMERS_PER_CHANNEL-1:0][31:0] pit_chan_count_type;

   function automatic logic [31:0] fill_limit(logic [31:0] slice);
      return (slice == 32'd0) ? 32'hFFFF_FFFF : slice;
   endfunction

   function automatic pit_chan_cmd_type restart_cmds(logic [2:0] mode, logic [3:0] toggles,
                                                     logic [3:0] en, logic [31:0] r);
      pit_chan_cmd_type c;
      logic [3:0]       go;
      go = toggles & en;
      for (int t = 0; t < TIMERS_PER_CHANNEL; t++) begin
         c[t].stop  = toggles[t];
         c[t].start = 1'b0;
         c[t].limit = 32'd0;
      end
      case (pit_mode_type'(mode))
         MODE_T32: begin
            c[0].start = go[0];  c[0].limit = fill_limit(r);
         end
         MODE_T16X2: begin
            c[0].start = go[0];  c[0].limit = fill_limit({16'd0, r[15:0]});
            c[1].start = go[1];  c[1].limit = fill_limit({16'd0, r[31:16]});
         end
         MODE_T8X4: begin
            c[0].start = go[0];  c[0].limit = fill_limit({24'd0, r[7:0]});
            c[1].start = go[1];  c[1].limit = fill_limit({24'd0, r[15:8]});
            c[2].start = go[2];  c[2].limit = fill_limit({24'd0, r[23:16]});
            c[3].start = go[3];  c[3].limit = fill_limit({24'd0, r[31:24]});
         end
         MODE_PWM16: begin
            c[2].start = go[3];  c[2].limit = fill_limit({16'd0, r[15:0]});
            c[3].start = go[3];  c[3].limit = fill_limit({16'd0, r[31:16]});
         end
         MODE_T16_PWM8: begin
            c[0].start = go[0];  c[0].limit = fill_limit({16'd0, r[15:0]});
            c[2].start = go[3];  c[2].limit = fill_limit({24'd0, r[23:16]});
            c[3].start = go[3];  c[3].limit = fill_limit({24'd0, r[31:24]});
         end
         MODE_T8X2_PWM8: begin
            c[0].start = go[0];  c[0].limit = fill_limit({24'd0, r[7:0]});
            c[1].start = go[1];  c[1].limit = fill_limit({24'd0, r[15:8]});
            c[2].start = go[3];  c[2].limit = fill_limit({24'd0, r[23:16]});
            c[3].start = go[3];  c[3].limit = fill_limit({24'd0, r[31:24]});
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   function automatic logic [31:0] packed_count(logic [2:0] mode, pit_chan_count_type c);
      logic [31:0] v;
      case (pit_mode_type'(mode))
         MODE_T32:       v = c[0];
         MODE_T16X2:     v = {c[1][15:0], c[0][15:0]};
         MODE_T8X4:      v = {c[3][7:0], c[2][7:0], c[1][7:0], c[0][7:0]};
         MODE_T8X2_PWM8: v = {c[3][7:0], c[2][7:0], c[1][7:0], c[0][7:0]};
         MODE_PWM16:     v = {c[3][15:0], c[2][15:0]};
         MODE_T16_PWM8:  v = {c[3][7:0], c[2][7:0], c[0][15:0]};
         default:        v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/core/pit_timers.sv @@
// Bank of sixteen down-counting sub-timers with reload and expiry flags.
module pit_timers import pit_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  pit_cmd_type [NUM_TIMERS-1:0]     cmds,
   input  logic [NUM_CHANNELS-1:0]          chan_tick,
   output logic [NUM_TIMERS-1:0][31:0]      counts,
   output logic [NUM_TIMERS-1:0]            hits
);

   logic [NUM_TIMERS-1:0][31:0] count_ff, count_in;
   logic [NUM_TIMERS-1:0][31:0] limit_ff, limit_in;
   logic [NUM_TIMERS-1:0]       running_ff, running_in;

   always_comb begin
      count_in   = count_ff;
      limit_in   = limit_ff;
      running_in = running_ff;
      hits       = '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         if (cmds[t].stop) begin
            running_in[t] = 1'b0;
         end
         if (cmds[t].start) begin
            running_in[t] = 1'b1;
            limit_in[t]   = cmds[t].limit;
            count_in[t]   = cmds[t].limit;
         end
         if (chan_tick[t / TIMERS_PER_CHANNEL] && running_ff[t]) begin
            if (count_ff[t] == 32'd0) begin
               count_in[t] = limit_ff[t];
               hits[t]     = 1'b1;
            end else begin
               count_in[t] = count_ff[t] - 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   assign counts = count_ff;

endmodule

@@ rtl/core/pit_regs.sv @@
// Bus register file: decode, read mux, interrupt logic and sub-timer start/stop control.
module pit_regs import pit_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  pit_item_type                     item,
   input  logic [NUM_TIMERS-1:0][31:0]      counts,
   input  logic [NUM_TIMERS-1:0]            hits,
   output pit_cmd_type [NUM_TIMERS-1:0]     cmds,
   output logic [NUM_CHANNELS-1:0]          chan_tick,
   output logic [31:0]                      read_data,
   output logic                             irq_level_in,
   output logic                             irq_line
);

   logic [31:0] irq_enable_ff, irq_enable_in;
   logic [31:0] irq_status_ff, irq_status_in;
   logic [31:0] timer_enable_ff, timer_enable_in;
   logic [NUM_CHANNELS-1:0][31:0] control_ff, control_in;
   logic [NUM_CHANNELS-1:0][31:0] reload_ff, reload_in;

   logic [31:0]             en_toggle;
   logic [NUM_CHANNELS-1:0] ctrl_toggle;
   logic [7:0]              ch_off8;
   logic                    ch_hit;
   logic [CH_W-1:0]         ch_sel;
   logic [3:0]              reg_off;
   logic                    is_write;
   logic                    is_tick;

   assign is_write = fire && (item.op == OP_WRITE);
   assign is_tick  = fire && (item.op == OP_TICK);
   assign ch_off8  = item.address - ADDR_CH_BASE;
   assign ch_hit   = ({1'b0, item.address} >= {1'b0, ADDR_CH_BASE}) &&
                     ({1'b0, item.address} < ADDR_CH_END);
   assign ch_sel   = ch_off8[4 +: CH_W];
   assign reg_off  = item.address[3:0];

   always_comb begin
      irq_enable_in   = irq_enable_ff;
      irq_status_in   = irq_status_ff;
      timer_enable_in = timer_enable_ff;
      control_in      = control_ff;
      reload_in       = reload_ff;
      en_toggle       = '0;
      ctrl_toggle     = '0;
      if (is_write) begin
         case (item.address)
            ADDR_IRQ_EN: irq_enable_in = item.write_data;
            ADDR_IRQ_ST: irq_status_in = irq_status_ff & ~item.write_data;
            ADDR_TMR_EN: begin
               en_toggle       = timer_enable_ff ^ item.write_data;
               timer_enable_in = item.write_data;
            end
            default: begin
               if (ch_hit) begin
                  if (reg_off == OFF_CTRL) begin
                     control_in[ch_sel]  = item.write_data;
                     ctrl_toggle[ch_sel] = |(control_ff[ch_sel][3:0] ^ item.write_data[3:0]);
                  end else if (reg_off == OFF_RELOAD) begin
                     reload_in[ch_sel] = item.write_data;
                  end
               end
            end
         endcase
      end
      if (is_tick) begin
         irq_status_in = irq_status_ff | 32'(hits);
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         cmds[ch*TIMERS_PER_CHANNEL +: TIMERS_PER_CHANNEL] =
            restart_cmds(control_in[ch][2:0],
                         en_toggle[ch*TIMERS_PER_CHANNEL +: TIMERS_PER_CHANNEL] |
                            {TIMERS_PER_CHANNEL{ctrl_toggle[ch]}},
                         timer_enable_in[ch*TIMERS_PER_CHANNEL +: TIMERS_PER_CHANNEL],
                         reload_ff[ch]);
         chan_tick[ch] = is_tick && (control_ff[ch][3] ? item.pclk_tick : item.ext_tick);
      end
   end

   always_comb begin
      read_data = 32'd0;
      if (item.op == OP_READ) begin
         case (item.address)
            ADDR_ID:     read_data = ID_VALUE;
            ADDR_CFG:    read_data = 32'(NUM_CHANNELS);
            ADDR_IRQ_EN: read_data = irq_enable_ff;
            ADDR_IRQ_ST: read_data = irq_status_ff;
            ADDR_TMR_EN: read_data = timer_enable_ff;
            default: begin
               if (ch_hit) begin
                  case (reg_off)
                     OFF_CTRL:   read_data = control_ff[ch_sel];
                     OFF_RELOAD: read_data = reload_ff[ch_sel];
                     OFF_COUNT:  read_data = packed_count(control_ff[ch_sel][2:0],
                                    counts[ch_sel*TIMERS_PER_CHANNEL +: TIMERS_PER_CHANNEL]);
                     default:    read_data = 32'd0;
                  endcase
               end
            end
         endcase
      end
   end

   assign irq_level_in = |(irq_enable_in & irq_status_in);
   assign irq_line     = |(irq_enable_ff & irq_status_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_enable_ff   <= '0;
         irq_status_ff   <= '0;
         timer_enable_ff <= '0;
         control_ff      <= '0;
         reload_ff       <= '0;
      end else begin
         irq_enable_ff   <= irq_enable_in;
         irq_status_ff   <= irq_status_in;
         timer_enable_ff <= timer_enable_in;
         control_ff      <= control_in;
         reload_ff       <= reload_in;
      end
   end

endmodule

@@ rtl/core/multi_mode_interval_timer_unit.sv @@
// Four-channel interval timer top level: input register, register file, timer bank, result register.
// Each request word is a bus read, a bus write or a clock tick; every request yields exactly
// one response word carrying read data (zero unless a read) and the interrupt level after the
// request. One request is taken per cycle while the response channel does not stall: the
// request lands in an input register, and a single pass through the register decode and the
// sixteen sub-timer updates writes the new state together with the response register. A read
// of a counter register sees the effect of every earlier request.
module multi_mode_interval_timer_unit import pit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_address,
   input  logic [31:0] req_write_data,
   input  logic        req_pclk_tick,
   input  logic        req_ext_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_level
);

   logic         in_valid_ff, in_valid_in;
   pit_item_type item_ff, item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_read_data_ff, rsp_read_data_in;
   logic         rsp_irq_level_ff, rsp_irq_level_in;

   logic advance;
   logic load;

   pit_cmd_type [NUM_TIMERS-1:0] cmds;
   logic [NUM_CHANNELS-1:0]      chan_tick;
   logic [NUM_TIMERS-1:0][31:0]  counts;
   logic [NUM_TIMERS-1:0]        hits;
   logic [31:0]                  read_data;
   logic                         irq_level_in;
   logic                         irq_line;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = advance ? 1'b0 : in_valid_ff;
      item_in     = item_ff;
      if (load) begin
         in_valid_in        = 1'b1;
         item_in.op         = pit_op_type'(req_operation);
         item_in.address    = req_address;
         item_in.write_data = req_write_data;
         item_in.pclk_tick  = req_pclk_tick;
         item_in.ext_tick   = req_ext_tick;
      end
   end

   always_comb begin
      rsp_valid_in     = advance || (rsp_valid_ff && rsp_stall);
      rsp_read_data_in = advance ? read_data : rsp_read_data_ff;
      rsp_irq_level_in = advance ? irq_level_in : rsp_irq_level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff          <= item_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_irq_level_ff <= rsp_irq_level_in;
   end

   pit_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (item_ff),
      .counts       (counts),
      .hits         (hits),
      .cmds         (cmds),
      .chan_tick    (chan_tick),
      .read_data    (read_data),
      .irq_level_in (irq_level_in),
      .irq_line     (irq_line)
   );

   pit_timers u_timers (
      .clock     (clock),
      .reset     (reset),
      .cmds      (cmds),
      .chan_tick (chan_tick),
      .counts    (counts),
      .hits      (hits)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_irq_level = rsp_irq_level_ff;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall && !advance)
      else $error("input word advanced while response blocked");

   a_zero_data_non_read: assert property (@(posedge clock) disable iff (reset)
      advance && (item_ff.op != OP_READ) |=> rsp_read_data_ff == 32'd0)
      else $error("non-read word produced nonzero read data");

   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_irq_level_ff == irq_line)
      else $error("response irq level disagrees with register state");

   a_no_tick_without_word: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (chan_tick == '0) && (hits == '0))
      else $error("timer activity without a word in flight");

endmodule

@@ sim/multi_mode_interval_timer_unit_checker.sv @@
// Predicts timer register and interrupt responses and compares them with the response channel.
`timescale 1ns / 100ps

module multi_mode_interval_timer_unit_checker import pit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_address,
   input  logic [31:0] req_write_data,
   input  logic        req_pclk_tick,
   input  logic        req_ext_tick,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_irq_level,
   output int          mismatch_count,
   output int          words_in_flight
);

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
   } timer_response_type;

   logic [31:0] irq_enable_r;
   logic [31:0] irq_status_r;
   logic [31:0] timer_enable_r;
   logic [31:0] control_r [NUM_CHANNELS];
   logic [31:0] reload_r [NUM_CHANNELS];
   logic [31:0] limit_r [NUM_TIMERS];
   logic [31:0] count_r [NUM_TIMERS];
   logic        running_r [NUM_TIMERS];

   timer_response_type awaited_responses [$];
   int                 mismatches = 0;

   task automatic clear_timer_state();
      irq_enable_r   = 32'd0;
      irq_status_r   = 32'd0;
      timer_enable_r = 32'd0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         control_r[c] = 32'd0;
         reload_r[c]  = 32'd0;
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
         limit_r[i]   = 32'd0;
         count_r[i]   = 32'd0;
         running_r[i] = 1'b0;
      end
   endtask

   task automatic arm_timer(int idx, logic [31:0] slice);
      limit_r[idx]   = (slice == 32'd0) ? 32'hFFFF_FFFF : slice;
      count_r[idx]   = limit_r[idx];
      running_r[idx] = 1'b1;
   endtask

   task automatic restart_channel(int ch, logic [3:0] toggles);
      int          b;
      logic [31:0] r;
      logic [3:0]  go;
      b  = ch * TIMERS_PER_CHANNEL;
      r  = reload_r[ch];
      go = toggles & timer_enable_r[ch * 4 +: 4];
      for (int t = 0; t < TIMERS_PER_CHANNEL; t++) begin
         if (toggles[t]) running_r[b + t] = 1'b0;
      end
      case (pit_mode_type'(control_r[ch][2:0]))
         MODE_T32: begin
            if (go[0]) arm_timer(b, r);
         end
         MODE_T16X2: begin
            if (go[0]) arm_timer(b, {16'd0, r[15:0]});
            if (go[1]) arm_timer(b + 1, {16'd0, r[31:16]});
         end
         MODE_T8X4: begin
            if (go[0]) arm_timer(b, {24'd0, r[7:0]});
            if (go[1]) arm_timer(b + 1, {24'd0, r[15:8]});
            if (go[2]) arm_timer(b + 2, {24'd0, r[23:16]});
            if (go[3]) arm_timer(b + 3, {24'd0, r[31:24]});
         end
         MODE_PWM16: begin
            if (go[3]) begin
               arm_timer(b + 2, {16'd0, r[15:0]});
               arm_timer(b + 3, {16'd0, r[31:16]});
            end
         end
         MODE_T16_PWM8: begin
            if (go[0]) arm_timer(b, {16'd0, r[15:0]});
            if (go[3]) begin
               arm_timer(b + 2, {24'd0, r[23:16]});
               arm_timer(b + 3, {24'd0, r[31:24]});
            end
         end
         MODE_T8X2_PWM8: begin
            if (go[0]) arm_timer(b, {24'd0, r[7:0]});
            if (go[1]) arm_timer(b + 1, {24'd0, r[15:8]});
            if (go[3]) begin
               arm_timer(b + 2, {24'd0, r[23:16]});
               arm_timer(b + 3, {24'd0, r[31:24]});
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [31:0] live_counts(int ch);
      int b;
      b = ch * TIMERS_PER_CHANNEL;
      case (pit_mode_type'(control_r[ch][2:0]))
         MODE_T32:       return count_r[b];
         MODE_T16X2:     return {count_r[b + 1][15:0], count_r[b][15:0]};
         MODE_T8X4,
         MODE_T8X2_PWM8: return {count_r[b + 3][7:0], count_r[b + 2][7:0],
                                 count_r[b + 1][7:0], count_r[b][7:0]};
         MODE_PWM16:     return {count_r[b + 3][15:0], count_r[b + 2][15:0]};
         MODE_T16_PWM8:  return {count_r[b + 3][7:0], count_r[b + 2][7:0], count_r[b][15:0]};
         default:        return 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] register_value(logic [7:0] a);
      int ch;
      case (a)
         ADDR_ID:     return ID_VALUE;
         ADDR_CFG:    return 32'(NUM_CHANNELS);
         ADDR_IRQ_EN: return irq_enable_r;
         ADDR_IRQ_ST: return irq_status_r;
         ADDR_TMR_EN: return timer_enable_r;
         default: begin
         end
      endcase
      if (a < ADDR_CH_BASE || {1'b0, a} >= ADDR_CH_END) return 32'd0;
      ch = int'(a - ADDR_CH_BASE) >> 4;
      if (a[3:0] == OFF_CTRL) return control_r[ch];
      if (a[3:0] == OFF_RELOAD) return reload_r[ch];
      if (a[3:0] == OFF_COUNT) return live_counts(ch);
      return 32'd0;
   endfunction

   task automatic register_write(logic [7:0] a, logic [31:0] v);
      int          ch;
      logic [31:0] flipped;
      case (a)
         ADDR_IRQ_EN: irq_enable_r = v;
         ADDR_IRQ_ST: irq_status_r &= ~v;
         ADDR_TMR_EN: begin
            flipped        = timer_enable_r ^ v;
            timer_enable_r = v;
            for (int c = 0; c < NUM_CHANNELS; c++) restart_channel(c, flipped[c * 4 +: 4]);
         end
         default: begin
            if (a >= ADDR_CH_BASE && {1'b0, a} < ADDR_CH_END) begin
               ch = int'(a - ADDR_CH_BASE) >> 4;
               if (a[3:0] == OFF_CTRL) begin
                  flipped       = control_r[ch] ^ v;
                  control_r[ch] = v;
                  if (flipped[3:0] != 4'd0) restart_channel(ch, 4'hF);
               end else if (a[3:0] == OFF_RELOAD) begin
                  reload_r[ch] = v;
               end
            end
         end
      endcase
   endtask

   task automatic count_down(logic pclk, logic ext);
      logic hit;
      int   idx;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         hit = control_r[c][3] ? pclk : ext;
         if (hit) begin
            for (int t = 0; t < TIMERS_PER_CHANNEL; t++) begin
               idx = c * TIMERS_PER_CHANNEL + t;
               if (running_r[idx]) begin
                  if (count_r[idx] == 32'd0) begin
                     count_r[idx]      = limit_r[idx];
                     irq_status_r[idx] = 1'b1;
                  end else begin
                     count_r[idx] = count_r[idx] - 32'd1;
                  end
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      timer_response_type want;
      logic [31:0]        rd;
      if (reset) begin
         clear_timer_state();
         awaited_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("unexpected response word: read_data %h irq_level %b",
                      rsp_read_data, rsp_irq_level);
               mismatches++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         want.read_data, rsp_read_data);
                  mismatches++;
               end
               if (rsp_irq_level !== want.irq_level) begin
                  $error("irq_level mismatch: expected %b, actual %b",
                         want.irq_level, rsp_irq_level);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            rd = 32'd0;
            case (req_operation)
               OP_READ:  rd = register_value(req_address);
               OP_WRITE: register_write(req_address, req_write_data);
               OP_TICK:  count_down(req_pclk_tick, req_ext_tick);
               default: begin
               end
            endcase
            awaited_responses.push_back({rd, |(irq_enable_r & irq_status_r)});
         end
      end
      mismatch_count  <= mismatches;
      words_in_flight <= awaited_responses.size();
   end

endmodule

@@ sim/multi_mode_interval_timer_unit_test.sv @@
// Stimulus and verdict for the four-channel interval timer with its response checker.
`timescale 1ns / 100ps

module multi_mode_interval_timer_unit_test;
   import pit_pkg::*;

   localparam logic [1:0] OP_UNUSED         = 2'd3;
   localparam logic [2:0] MODE_RESERVED_LOW = 3'd0;
   localparam logic [2:0] MODE_RESERVED_MID = 3'd5;
   localparam logic [7:0] CH_STRIDE         = 8'h10;
   localparam int         RANDOM_WORDS      = 1750;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation  = OP_READ;
   logic [7:0]  req_address    = 8'd0;
   logic [31:0] req_write_data = 32'd0;
   logic        req_pclk_tick  = 1'b0;
   logic        req_ext_tick   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_level;

   int mismatch_count;
   int words_in_flight;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int words_sent         = 0;

   multi_mode_interval_timer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_pclk_tick  (req_pclk_tick),
      .req_ext_tick   (req_ext_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_level  (rsp_irq_level)
   );

   multi_mode_interval_timer_unit_checker response_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_pclk_tick   (req_pclk_tick),
      .req_ext_tick    (req_ext_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_level   (rsp_irq_level),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic send_word(logic [1:0] op, logic [7:0] addr, logic [31:0] data,
                            logic pclk, logic ext);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_address    <= addr;
      req_write_data <= data;
      req_pclk_tick  <= pclk;
      req_ext_tick   <= ext;
      do @(posedge clock); while (req_stall);
      if (op != OP_UNUSED) words_sent++;
   endtask

   function automatic logic [31:0] short_slice(int bits);
      logic [31:0] mask;
      mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
      if ($urandom_range(9) == 0) return $urandom & mask;
      return $urandom_range(7);
   endfunction

   function automatic logic [31:0] pick_reload(logic [2:0] mode);
      logic [31:0] s0, s1, s2, s3;
      case (pit_mode_type'(mode))
         MODE_T32: return short_slice(32);
         MODE_T16X2, MODE_PWM16: begin
            s0 = short_slice(16);
            s1 = short_slice(16);
            return {s1[15:0], s0[15:0]};
         end
         MODE_T16_PWM8: begin
            s0 = short_slice(16);
            s2 = short_slice(8);
            s3 = short_slice(8);
            return {s3[7:0], s2[7:0], s0[15:0]};
         end
         default: begin
            s0 = short_slice(8);
            s1 = short_slice(8);
            s2 = short_slice(8);
            s3 = short_slice(8);
            return {s3[7:0], s2[7:0], s1[7:0], s0[7:0]};
         end
      endcase
   endfunction

   task automatic run_channel_scene();
      int          ch;
      int          pick;
      logic [2:0]  mode;
      logic [31:0] ctrl;
      logic [7:0]  base;
      ch   = $urandom_range(NUM_CHANNELS - 1);
      base = ADDR_CH_BASE + 8'(ch) * CH_STRIDE;
      if ($urandom_range(7) == 0)
         mode = $urandom_range(1) ? MODE_RESERVED_LOW : MODE_RESERVED_MID;
      else
         mode = 3'($urandom_range(1, 7));
      ctrl      = $urandom;
      ctrl[2:0] = mode;
      send_word(OP_WRITE, base + OFF_RELOAD, pick_reload(mode), 1'b0, 1'b0);
      send_word(OP_WRITE, base + OFF_CTRL, ctrl, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_TMR_EN, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom,
                1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_IRQ_EN, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom,
                1'b0, 1'b0);
      repeat ($urandom_range(5, 40)) begin
         pick = $urandom_range(99);
         if (pick < 65)
            send_word(OP_TICK, 8'($urandom), $urandom, $urandom_range(3) != 0,
                      $urandom_range(3) != 0);
         else if (pick < 75)
            send_word(OP_READ, base + OFF_COUNT, $urandom, 1'b0, 1'b0);
         else if (pick < 83)
            send_word(OP_READ, ADDR_IRQ_ST, $urandom, 1'b0, 1'b0);
         else if (pick < 90)
            send_word(OP_WRITE, ADDR_IRQ_ST, $urandom, 1'b0, 1'b0);
         else if (pick < 94)
            send_word(OP_WRITE, base + OFF_RELOAD, pick_reload(mode), 1'b0, 1'b0);
         else if (pick < 97)
            send_word(OP_WRITE, ADDR_TMR_EN, $urandom, 1'b0, 1'b0);
         else
            send_word(OP_READ,
                      ADDR_CH_BASE + 8'($urandom_range(NUM_CHANNELS * 4 - 1)) * 8'd4,
                      $urandom, 1'b0, 1'b0);
      end
   endtask

   task automatic send_noise();
      logic [7:0] addr;
      addr = $urandom_range(1) ? 8'($urandom) : ADDR_CH_BASE + 8'($urandom_range(63));
      send_word(2'($urandom_range(3)), addr, $urandom, 1'($urandom), 1'($urandom));
   endtask

   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_READ, ADDR_ID, 32'd0, 1'b0, 1'b0);
      send_word(OP_READ, ADDR_CFG, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_word(OP_WRITE, ADDR_ID, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_word(OP_READ, 8'h03, 32'd0, 1'b0, 1'b0);
      send_word(OP_READ, 8'hFF, 32'd0, 1'b0, 1'b0);
      send_word(OP_UNUSED, ADDR_IRQ_EN, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_word(OP_WRITE, ADDR_IRQ_EN, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_CH_BASE + OFF_RELOAD, 32'h0001_0100, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_CH_BASE + OFF_CTRL, {28'hFFF_FFFF, 1'b1, MODE_T8X4},
                1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_TMR_EN, 32'h0000_000F, 1'b0, 1'b0);
      send_word(OP_TICK, 8'd0, 32'd0, 1'b1, 1'b0);
      send_word(OP_TICK, 8'd0, 32'd0, 1'b1, 1'b1);
      send_word(OP_TICK, 8'd0, 32'd0, 1'b1, 1'b0);
      send_word(OP_READ, ADDR_CH_BASE + OFF_COUNT, 32'd0, 1'b0, 1'b0);
      send_word(OP_READ, ADDR_IRQ_ST, 32'd0, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_IRQ_ST, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_CH_BASE + CH_STRIDE + OFF_CTRL,
                {28'd0, 1'b0, MODE_RESERVED_MID}, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_TMR_EN, 32'h0000_00FF, 1'b0, 1'b0);
      send_word(OP_TICK, 8'd0, 32'd0, 1'b0, 1'b1);
      send_word(OP_READ, ADDR_CH_BASE + CH_STRIDE + OFF_COUNT, 32'd0, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_CH_BASE + OFF_COUNT, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_CH_BASE + OFF_RELOAD, 32'd0, 1'b0, 1'b0);
      send_word(OP_TICK, 8'd0, 32'd0, 1'b0, 1'b0);
      send_word(OP_WRITE, ADDR_TMR_EN, 32'd0, 1'b0, 1'b0);
      send_word(OP_READ, ADDR_TMR_EN, 32'd0, 1'b0, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         target = words_sent + RANDOM_WORDS / 4;
         while (words_sent < target) begin
            if ($urandom_range(4) == 0) send_noise();
            else run_channel_scene();
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (words_in_flight != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/pit_pkg.sv
rtl/core/pit_timers.sv
rtl/core/pit_regs.sv
rtl/core/multi_mode_interval_timer_unit.sv
sim/multi_mode_interval_timer_unit_checker.sv
sim/multi_mode_interval_timer_unit_test.sv
